FILE: rtl/radix_convert_to_digits_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef RADIX_CONVERT_TO_DIGITS_MACROS_SVH
`define RADIX_CONVERT_TO_DIGITS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rcd_pkg.sv
`default_nettype none
package rcd_pkg;

	localparam int VALUE_W = 63;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
	localparam logic [CHAR_W-1:0]  CHAR_F    = 7'h46;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		logic               bad;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		if (d < 4'd10) begin
			return CHAR_ZERO + {3'b000, d};
		end else begin
			return CHAR_A + {3'b000, d - 4'd10};
		end
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rcd_ram.sv
`default_nettype none
module rcd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/rcd_front.sv
`default_nettype none
module rcd_front
	import rcd_pkg::*;
(
	input  wire                start,
	input  wire [VALUE_W-1:0]  value,
	input  wire [RADIX_W-1:0]  radix,
	input  qstat_t             qstat,
	output logic               busy,
	output logic               push,
	output item_t              item
);

	// The front only refuses an item when the queue has no room for it.
	assign busy = qstat.full;
	assign push = start && !qstat.full;

	always_comb begin
		item.value = value;
		item.radix = radix;
		item.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	end

endmodule
`default_nettype wire

FILE: rtl/rcd_queue.sv
`default_nettype none
module rcd_queue
	import rcd_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  item_t  push_item,
	input  wire    pop,
	output item_t  pop_item,
	output qstat_t qstat
);

	localparam int Depth = 2;

	item_t      mem_q [Depth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item    = mem_q[rd_ptr_q];
	assign qstat.empty = (cnt_q == 2'd0);
	assign qstat.full  = (cnt_q == 2'(Depth));

endmodule
`default_nettype wire

FILE: rtl/rcd_back.sv
`default_nettype none
module rcd_back
	import rcd_pkg::*;
#(
	parameter int MAX_DIGITS = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  qstat_t             qstat,
	input  item_t              pop_item,
	output logic               pop,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last_digit,
	output logic               bad_radix
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]          state_q;
	logic [63:0]         work_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [2:0]          step_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       rd_ptr_q;

	logic                vld_s1;
	logic                last_s1;
	logic                err_s1;

	logic [DIGIT_W-1:0]  div_rem;
	logic [RADIX_W-1:0]  div_part;
	logic [7:0]          div_quot;
	logic [63:0]         work_next;
	logic [CW-1:0]       cnt_inc;
	logic                div_done;
	logic                ram_we;
	logic [DIGIT_W-1:0]  ram_rdata;

	// Eight restoring steps of long division by the radix per cycle.
	always_comb begin
		div_rem  = rem_q;
		div_part = '0;
		div_quot = '0;
		for (int i = 7; i >= 0; i--) begin
			div_part = {div_rem, work_q[56 + i]};
			if (div_part >= radix_q) begin
				div_quot[i] = 1'b1;
				div_rem     = DIGIT_W'(div_part - radix_q);
			end else begin
				div_rem = div_part[DIGIT_W-1:0];
			end
		end
	end

	assign work_next = {work_q[55:0], div_quot};
	assign cnt_inc   = cnt_q + CW'(1);
	assign ram_we    = (state_q == ST_DIV) && (step_q == 3'd7);
	assign div_done  = (work_next == '0) || (cnt_inc == CW'(MAX_DIGITS));
	assign pop       = (state_q == ST_IDLE) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= 3'd0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			err_s1   <= 1'b0;
		end else begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			err_s1  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (pop_item.bad) begin
							vld_s1  <= 1'b1;
							last_s1 <= 1'b1;
							err_s1  <= 1'b1;
						end else begin
							step_q  <= 3'd0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						cnt_q <= cnt_inc;
						if (div_done) begin
							rd_ptr_q <= cnt_q[AW-1:0];
							state_q  <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					vld_s1  <= 1'b1;
					last_s1 <= (rd_ptr_q == '0);
					if (rd_ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_ptr_q <= rd_ptr_q - AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q  <= {1'b0, pop_item.value};
			radix_q <= pop_item.radix;
			rem_q   <= '0;
		end else if (state_q == ST_DIV) begin
			work_q <= work_next;
			rem_q  <= (step_q == 3'd7) ? '0 : div_rem;
		end
	end

	rcd_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(div_rem),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		digit_char <= err_s1 ? CHAR_ZERO : to_ascii(ram_rdata);
		last_digit <= last_s1;
		bad_radix  <= err_s1;
	end

endmodule
`default_nettype wire

FILE: rtl/radix_convert_to_digits.sv
`default_nettype none
// Converts a 63-bit unsigned value to ASCII digits in a base from 2 to 16, most significant
// digit first, one character per cycle marked by strobe, the final one with last_digit. The
// receiver cannot hold results off, so every strobe must be taken as it comes. A base outside
// 2 to 16 gives a single '0' with bad_radix and last_digit set. Items are taken while busy is
// low; busy rises only when the two-item queue in front of the converter is full. Each digit
// is the remainder of a pass through the divider, which retires eight quotient bits a cycle,
// and is written to the store; the digits are then read back and emitted, and the converter
// takes no new item from the queue until it has read the last digit of the current one back.
module radix_convert_to_digits
	import rcd_pkg::*;
#(
	parameter int MAX_DIGITS = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire [VALUE_W-1:0]  value,
	input  wire [RADIX_W-1:0]  radix,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last_digit,
	output logic               bad_radix
);

	qstat_t qstat;
	logic   push;
	logic   pop;
	item_t  push_item;
	item_t  pop_item;

	rcd_front u_front (
		.start(start),
		.value(value),
		.radix(radix),
		.qstat(qstat),
		.busy (busy),
		.push (push),
		.item (push_item)
	);

	rcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.qstat    (qstat)
	);

	rcd_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_item  (pop_item),
		.pop       (pop),
		.strobe    (strobe),
		.digit_char(digit_char),
		.last_digit(last_digit),
		.bad_radix (bad_radix)
	);

`include "radix_convert_to_digits_macros.svh"

	`RCD_ASSERT_NOW(a_no_push_full, qstat.full, !push, "item pushed into a full queue")
	`RCD_ASSERT_NOW(a_no_pop_empty, qstat.empty, !pop, "item popped from an empty queue")
	`RCD_ASSERT_NOW(a_bad_single, strobe && bad_radix,
		last_digit && (digit_char == CHAR_ZERO), "bad radix result is not a lone zero")
	`RCD_ASSERT_NOW(a_char_range, strobe,
		((digit_char >= CHAR_ZERO) && (digit_char <= CHAR_F)), "digit character out of range")

endmodule
`default_nettype wire

FILE: tb/sv/tb_radix_convert_to_digits.sv
`timescale 1ns / 1ps

module tb_radix_convert_to_digits;
	import rcd_pkg::*;

	localparam int DIGIT_LIMIT = 64;
	localparam int TAIL_CYCLES = 700;
	localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		int                 idle_pct;
		bit                 drain;
	} conv_job_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} char_due_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [VALUE_W-1:0] value = '0;
	logic [RADIX_W-1:0] radix = '0;
	logic busy;
	logic strobe;
	logic [CHAR_W-1:0] digit_char;
	logic last_digit;
	logic bad_radix;

	conv_job_t pending[$];
	char_due_t chars_due[$];
	logic item_taken = 1'b0;
	int errors = 0;
	int items_taken = 0;
	int bad_items = 0;
	int chars_checked = 0;

	radix_convert_to_digits #(
		.MAX_DIGITS(DIGIT_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.radix(radix),
		.strobe(strobe),
		.digit_char(digit_char),
		.last_digit(last_digit),
		.bad_radix(bad_radix)
	);

	always #5 clk = ~clk;

	function automatic void convert_to_chars(input logic [VALUE_W-1:0] v,
			input logic [RADIX_W-1:0] r);
		logic [63:0] rest;
		int digits[$];
		int n;
		char_due_t c;
		if (r < RADIX_MIN || r > RADIX_MAX) begin
			c.ch = CHAR_ZERO;
			c.last = 1'b1;
			c.bad = 1'b1;
			chars_due.push_back(c);
			bad_items++;
			return;
		end
		rest = {1'b0, v};
		n = 0;
		do begin
			digits.push_front(int'(rest % r));
			n++;
			rest = rest / r;
		end while (rest != 0 && n < DIGIT_LIMIT);
		foreach (digits[i]) begin
			c.ch = CHAR_W'((digits[i] < 10) ? CHAR_ZERO + digits[i]
				: CHAR_A + (digits[i] - 10));
			c.last = (i == digits.size() - 1);
			c.bad = 1'b0;
			chars_due.push_back(c);
		end
	endfunction

	function automatic void add_job(input logic [VALUE_W-1:0] v,
			input logic [RADIX_W-1:0] r, input int idle_pct, input bit drain);
		conv_job_t j;
		j.value = v;
		j.radix = r;
		j.idle_pct = idle_pct;
		j.drain = drain;
		pending.push_back(j);
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		logic [63:0] raw;
		int w;
		raw = {$urandom, $urandom};
		w = ($urandom_range(99) < 30) ? VALUE_W : $urandom_range(VALUE_W, 0);
		return raw[VALUE_W-1:0] & VALUE_W'((64'd1 << w) - 64'd1);
	endfunction

	function automatic logic [RADIX_W-1:0] random_radix();
		int r;
		if ($urandom_range(99) < 88) begin
			return RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
		end
		r = $urandom_range(16, 0);
		return RADIX_W'((r < 2) ? r : r + 15);
	endfunction

	// The current item stays on the inputs until it is taken; a new one may follow at once.
	always @(negedge clk) begin
		conv_job_t nxt;
		if (arst_n && !(start && !item_taken)) begin
			if (pending.size() != 0 && !(pending[0].drain && chars_due.size() != 0)
					&& $urandom_range(99) >= pending[0].idle_pct) begin
				nxt = pending.pop_front();
				start <= 1'b1;
				value <= nxt.value;
				radix <= nxt.radix;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		char_due_t want;
		if (arst_n) begin
			if (strobe) begin
				if (chars_due.size() == 0) begin
					$error("unexpected character: digit_char %h last_digit %b bad_radix %b",
						digit_char, last_digit, bad_radix);
					errors++;
				end else begin
					want = chars_due.pop_front();
					chars_checked++;
					if (digit_char !== want.ch) begin
						$error("digit_char: expected %h, got %h", want.ch, digit_char);
						errors++;
					end
					if (last_digit !== want.last) begin
						$error("last_digit: expected %b, got %b", want.last, last_digit);
						errors++;
					end
					if (bad_radix !== want.bad) begin
						$error("bad_radix: expected %b, got %b", want.bad, bad_radix);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				convert_to_chars(value, radix);
				items_taken++;
			end
			item_taken <= start && !busy;
		end
	end

	initial begin
		int idle;
		add_job('0, 5'd10, 31, 1'b0);
		add_job('0, 5'd2, 31, 1'b0);
		add_job(63'd1, 5'd16, 31, 1'b0);
		add_job(VALUE_TOP, 5'd2, 31, 1'b0);
		add_job(VALUE_TOP, 5'd16, 31, 1'b0);
		add_job(VALUE_TOP, 5'd3, 31, 1'b0);
		add_job(VALUE_TOP, 5'd10, 31, 1'b0);
		add_job(63'h0123_4567_89AB_CDEF, 5'd16, 31, 1'b0);
		add_job(63'd15, 5'd16, 31, 1'b0);
		add_job(63'd16, 5'd16, 31, 1'b0);
		add_job(63'd9, 5'd10, 31, 1'b0);
		add_job(63'd10, 5'd10, 31, 1'b0);
		add_job(63'd14, 5'd15, 31, 1'b0);
		add_job(63'd123, 5'd0, 31, 1'b0);
		add_job(63'd5, 5'd1, 31, 1'b0);
		add_job(VALUE_TOP, 5'd17, 31, 1'b0);
		add_job('0, 5'd31, 31, 1'b0);
		add_job(63'h5555_5555_5555_5555, 5'd2, 31, 1'b0);
		add_job(63'h2AAA_AAAA_AAAA_AAAA, 5'd2, 31, 1'b0);
		add_job(63'h4000_0000_0000_0000, 5'd4, 31, 1'b0);
		add_job(63'd255, 5'd16, 31, 1'b1);
		add_job(63'd1_000_000_007, 5'd7, 0, 1'b0);
		for (int i = 0; i < 420; i++) begin
			idle = (i < 140) ? 31 : (i < 280) ? 73 : 0;
			add_job(random_value(), random_radix(), idle,
				(i % 140 == 0) || ($urandom_range(99) < 2));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || start || chars_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (chars_due.size() != 0) begin
			$error("%0d characters never arrived", chars_due.size());
			errors++;
		end
		$display("Converted %0d items over bases 0 to 31, %0d of them with a bad radix.",
			items_taken, bad_items);
		$display("Checked %0d characters, %0d mismatches.", chars_checked, errors);
		if (errors == 0) begin
			$display("** radix_convert_to_digits: PASSED **");
		end else begin
			$display("** radix_convert_to_digits: FAILED **");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d items and %0d characters outstanding.",
			pending.size(), chars_due.size());
		$display("** radix_convert_to_digits: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rcd_pkg.sv
rtl/rcd_ram.sv
rtl/rcd_front.sv
rtl/rcd_queue.sv
rtl/rcd_back.sv
rtl/radix_convert_to_digits.sv
tb/sv/tb_radix_convert_to_digits.sv
